/* hw/rtl/gte_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Graph traversal engine package
// Shared widths, command codes and result status codes.
// ----------------------------------------------------------------------------
package gte_pkg;

    localparam int MODE_W        = 3;
    localparam int NODE_W        = 6;
    localparam int STATUS_W      = 3;
    localparam int COUNT_W       = 11;
    localparam int MAX_NODES_DEF = 32;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 11'd2047;

    localparam logic [MODE_W-1:0] MODE_ADD_NODE = 3'd0;
    localparam logic [MODE_W-1:0] MODE_ADD_EDGE = 3'd1;
    localparam logic [MODE_W-1:0] MODE_DEL_EDGE = 3'd2;
    localparam logic [MODE_W-1:0] MODE_BFS      = 3'd3;
    localparam logic [MODE_W-1:0] MODE_DFS      = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_MISSING = 3'd2;
    localparam logic [STATUS_W-1:0] ST_EXISTS  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_ABSENT  = 3'd4;
    localparam logic [STATUS_W-1:0] ST_FULL    = 3'd5;

endpackage

/* hw/rtl/gte_cmd_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Command channel
// Valid/ready channel that carries one command beat.
// ----------------------------------------------------------------------------
interface gte_cmd_if
    import gte_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic [NODE_W-1:0] node_a;
    logic [NODE_W-1:0] node_b;

    modport source (output valid, output mode, output node_a, output node_b, input ready);
    modport sink   (input valid, input mode, input node_a, input node_b, output ready);
endinterface

/* hw/rtl/gte_rsp_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel that carries one result beat.
// ----------------------------------------------------------------------------
interface gte_rsp_if
    import gte_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [NODE_W-1:0]   visit_node;
    logic [COUNT_W-1:0]  revisit_count;
    logic                last;

    modport source (output valid, output status, output visit_node,
                    output revisit_count, output last, input ready);
    modport sink   (input valid, input status, input visit_node,
                    input revisit_count, input last, output ready);
endinterface

/* hw/rtl/graph_traversal_engine.sv */
`timescale 1ns / 1ps
// Add node passes through decode and a response state. An edge command scans the list
// entries through the read port, and a delete then shifts each later entry with a read
// and a write. A traversal pops, emits and scans each visited node's neighbor entries;
// the single neighbor memory read port paces the scans. One command at a time; the next
// is taken when the last beat is registered. Reset clears node count, degrees, visited
// flags and control state.
// ----------------------------------------------------------------------------
// Graph traversal engine
// Undirected graph in per-node neighbor lists with edge editing and
// breadth-first or depth-first traversal under a small sequencer.
// ----------------------------------------------------------------------------
module graph_traversal_engine
    import gte_pkg::*;
#(
    parameter int MAX_NODES = MAX_NODES_DEF
)
(
    input logic       clk,
    input logic       rst_n,
    gte_cmd_if.sink   cmd,
    gte_rsp_if.source rsp
);

    localparam int NW = $clog2(MAX_NODES + 1);
    localparam int IW = $clog2(MAX_NODES);
    localparam int DW = $clog2(MAX_NODES + 1);
    localparam int AW = $clog2(MAX_NODES * MAX_NODES);
    localparam int MD = MAX_NODES * MAX_NODES;

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_DEC       = 4'd1;
    localparam logic [3:0] S_SCAN      = 4'd2;
    localparam logic [3:0] S_SCAN_DONE = 4'd3;
    localparam logic [3:0] S_SH_RD     = 4'd4;
    localparam logic [3:0] S_SH_WR     = 4'd5;
    localparam logic [3:0] S_POP       = 4'd6;
    localparam logic [3:0] S_EMIT      = 4'd7;
    localparam logic [3:0] S_FIN       = 4'd8;
    localparam logic [3:0] S_RESP      = 4'd9;

    logic [3:0]          state_reg, state_next;
    logic [MODE_W-1:0]   mode_reg, mode_next;
    logic [NODE_W-1:0]   a_reg, a_next;
    logic [NODE_W-1:0]   b_reg, b_next;
    logic [DW-1:0]       node_total_reg, node_total_next;
    logic [DW-1:0]       deg_reg [MAX_NODES];
    logic [DW-1:0]       deg_next [MAX_NODES];
    logic [MAX_NODES-1:0] visited_reg, visited_next;
    logic [NW-1:0]       wl_reg [MAX_NODES];
    logic [DW-1:0]       head_reg, head_next;
    logic [DW-1:0]       tail_reg, tail_next;
    logic [COUNT_W-1:0]  cnt_reg, cnt_next;
    logic [DW-1:0]       emitted_reg, emitted_next;
    logic [NW-1:0]       held_reg, held_next;
    logic                held_valid_reg, held_valid_next;
    logic [NW-1:0]       cur_reg, cur_next;
    logic [NW-1:0]       sn_reg, sn_next;
    logic [NW-1:0]       sv_reg, sv_next;
    logic [DW-1:0]       k_reg, k_next;
    logic [DW-1:0]       kd_reg, kd_next;
    logic                pend_reg, pend_next;
    logic                found_reg, found_next;
    logic [DW-1:0]       pos_reg, pos_next;
    logic                phase_reg, phase_next;
    logic [STATUS_W-1:0] st_reg, st_next;
    logic [NODE_W-1:0]   num_reg, num_next;

    logic                rsp_valid_reg, rsp_valid_next;
    logic [STATUS_W-1:0] rsp_status_reg, rsp_status_next;
    logic [NODE_W-1:0]   rsp_num_reg, rsp_num_next;
    logic [COUNT_W-1:0]  rsp_cnt_reg, rsp_cnt_next;
    logic                rsp_last_reg, rsp_last_next;

    logic [NW-1:0]       mem [MD];
    logic [NW-1:0]       rd_data_reg;
    logic                mem_we, mem_re;
    logic [AW-1:0]       mem_waddr, mem_raddr;
    logic [NW-1:0]       mem_wdata;

    logic                wl_we;
    logic [IW-1:0]       wl_idx;
    logic [NW-1:0]       wl_data;

    logic [IW-1:0]       sn_idx;
    logic [DW-1:0]       sdeg;
    logic                out_free;

    assign sn_idx   = IW'(sn_reg - NW'(1));
    assign sdeg     = deg_reg[sn_idx];
    assign out_free = !rsp_valid_reg || rsp.ready;

    assign cmd.ready         = (state_reg == S_IDLE);
    assign rsp.valid         = rsp_valid_reg;
    assign rsp.status        = rsp_status_reg;
    assign rsp.visit_node    = rsp_num_reg;
    assign rsp.revisit_count = rsp_cnt_reg;
    assign rsp.last          = rsp_last_reg;

    always_comb
    begin
        logic          bad_a;
        logic          bad_b;
        logic [IW-1:0] a_idx;
        logic [IW-1:0] b_idx;
        logic [IW-1:0] e_idx;
        logic [NW-1:0] ent;
        logic [NW-1:0] pop_node;
        logic          stop;

        state_next      = state_reg;
        mode_next       = mode_reg;
        a_next          = a_reg;
        b_next          = b_reg;
        node_total_next = node_total_reg;
        deg_next        = deg_reg;
        visited_next    = visited_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        cnt_next        = cnt_reg;
        emitted_next    = emitted_reg;
        held_next       = held_reg;
        held_valid_next = held_valid_reg;
        cur_next        = cur_reg;
        sn_next         = sn_reg;
        sv_next         = sv_reg;
        k_next          = k_reg;
        kd_next         = kd_reg;
        pend_next       = pend_reg;
        found_next      = found_reg;
        pos_next        = pos_reg;
        phase_next      = phase_reg;
        st_next         = st_reg;
        num_next        = num_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp.ready;
        rsp_status_next = rsp_status_reg;
        rsp_num_next    = rsp_num_reg;
        rsp_cnt_next    = rsp_cnt_reg;
        rsp_last_next   = rsp_last_reg;
        mem_we          = 1'b0;
        mem_re          = 1'b0;
        mem_waddr       = '0;
        mem_raddr       = '0;
        mem_wdata       = '0;
        wl_we           = 1'b0;
        wl_idx          = '0;
        wl_data         = '0;

        bad_a    = (a_reg == '0) || (a_reg > NODE_W'(node_total_reg));
        bad_b    = (b_reg == '0) || (b_reg > NODE_W'(node_total_reg));
        a_idx    = IW'(a_reg - NODE_W'(1));
        b_idx    = IW'(b_reg - NODE_W'(1));
        ent      = rd_data_reg;
        e_idx    = IW'(ent - NW'(1));
        pop_node = '0;
        stop     = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd.valid)
                begin
                    mode_next  = cmd.mode;
                    a_next     = cmd.node_a;
                    b_next     = cmd.node_b;
                    phase_next = 1'b0;
                    state_next = S_DEC;
                end
            end
            S_DEC:
            begin
                num_next   = '0;
                state_next = S_RESP;
                if (mode_reg > MODE_DFS)
                begin
                    state_next = S_IDLE;
                end
                else if (mode_reg == MODE_ADD_NODE)
                begin
                    if (node_total_reg >= DW'(MAX_NODES))
                    begin
                        st_next = ST_FULL;
                    end
                    else
                    begin
                        deg_next[IW'(node_total_reg)] = '0;
                        node_total_next = node_total_reg + DW'(1);
                        st_next  = ST_OK;
                        num_next = NODE_W'(node_total_reg + DW'(1));
                    end
                end
                else if (node_total_reg == '0)
                begin
                    st_next = ST_EMPTY;
                end
                else if (mode_reg == MODE_ADD_EDGE || mode_reg == MODE_DEL_EDGE)
                begin
                    if (bad_a || bad_b)
                    begin
                        st_next = ST_MISSING;
                    end
                    else
                    begin
                        sn_next    = NW'(a_reg);
                        sv_next    = NW'(b_reg);
                        k_next     = '0;
                        pend_next  = 1'b0;
                        found_next = 1'b0;
                        state_next = S_SCAN;
                    end
                end
                else if (bad_a)
                begin
                    st_next = ST_MISSING;
                end
                else
                begin
                    visited_next        = '0;
                    visited_next[a_idx] = 1'b1;
                    wl_we           = 1'b1;
                    wl_idx          = '0;
                    wl_data         = NW'(a_reg);
                    head_next       = '0;
                    tail_next       = DW'(1);
                    cnt_next        = '0;
                    emitted_next    = '0;
                    held_valid_next = 1'b0;
                    state_next      = S_POP;
                end
            end
            S_SCAN:
            begin
                if (pend_reg)
                begin
                    if (mode_reg == MODE_ADD_EDGE || mode_reg == MODE_DEL_EDGE)
                    begin
                        if (ent == sv_reg)
                        begin
                            found_next = 1'b1;
                            pos_next   = kd_reg;
                            stop       = 1'b1;
                        end
                    end
                    else if (ent != '0 && int'(ent) <= MAX_NODES)
                    begin
                        if (!visited_reg[e_idx] && tail_reg < DW'(MAX_NODES))
                        begin
                            wl_we               = 1'b1;
                            wl_idx              = tail_reg[IW-1:0];
                            wl_data             = ent;
                            tail_next           = tail_reg + DW'(1);
                            visited_next[e_idx] = 1'b1;
                        end
                        else if (cnt_reg < COUNT_MAX)
                        begin
                            cnt_next = cnt_reg + COUNT_W'(1);
                        end
                    end
                end
                if (!stop && k_reg < sdeg)
                begin
                    mem_re    = 1'b1;
                    mem_raddr = AW'(int'(sn_idx) * MAX_NODES + int'(k_reg));
                    kd_next   = k_reg;
                    k_next    = k_reg + DW'(1);
                    pend_next = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                    if (mode_reg == MODE_ADD_EDGE || mode_reg == MODE_DEL_EDGE)
                    begin
                        state_next = S_SCAN_DONE;
                    end
                    else
                    begin
                        state_next = S_POP;
                    end
                end
            end
            S_SCAN_DONE:
            begin
                st_next    = ST_OK;
                state_next = S_RESP;
                if (mode_reg == MODE_ADD_EDGE)
                begin
                    if (!phase_reg)
                    begin
                        if (found_reg)
                        begin
                            st_next = ST_EXISTS;
                        end
                        else if (deg_reg[a_idx] >= DW'(MAX_NODES) ||
                                 deg_reg[b_idx] >= DW'(MAX_NODES))
                        begin
                            st_next = ST_FULL;
                        end
                        else
                        begin
                            mem_we    = 1'b1;
                            mem_waddr = AW'(int'(a_idx) * MAX_NODES + int'(deg_reg[a_idx]));
                            mem_wdata = NW'(b_reg);
                            deg_next[a_idx] = deg_reg[a_idx] + DW'(1);
                            if (a_reg != b_reg)
                            begin
                                sn_next    = NW'(b_reg);
                                sv_next    = NW'(a_reg);
                                k_next     = '0;
                                pend_next  = 1'b0;
                                found_next = 1'b0;
                                phase_next = 1'b1;
                                state_next = S_SCAN;
                            end
                        end
                    end
                    else if (!found_reg)
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = AW'(int'(b_idx) * MAX_NODES + int'(deg_reg[b_idx]));
                        mem_wdata = NW'(a_reg);
                        deg_next[b_idx] = deg_reg[b_idx] + DW'(1);
                    end
                end
                else if (!found_reg)
                begin
                    if (!phase_reg)
                    begin
                        st_next = ST_ABSENT;
                    end
                end
                else
                begin
                    k_next     = pos_reg;
                    state_next = S_SH_RD;
                end
            end
            S_SH_RD:
            begin
                if ({1'b0, k_reg} + (DW + 1)'(1) < {1'b0, sdeg})
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = AW'(int'(sn_idx) * MAX_NODES + int'(k_reg) + 1);
                    state_next = S_SH_WR;
                end
                else
                begin
                    deg_next[sn_idx] = sdeg - DW'(1);
                    st_next          = ST_OK;
                    state_next       = S_RESP;
                    if (!phase_reg && a_reg != b_reg)
                    begin
                        sn_next    = NW'(b_reg);
                        sv_next    = NW'(a_reg);
                        k_next     = '0;
                        pend_next  = 1'b0;
                        found_next = 1'b0;
                        phase_next = 1'b1;
                        state_next = S_SCAN;
                    end
                end
            end
            S_SH_WR:
            begin
                mem_we     = 1'b1;
                mem_waddr  = AW'(int'(sn_idx) * MAX_NODES + int'(k_reg));
                mem_wdata  = rd_data_reg;
                k_next     = k_reg + DW'(1);
                state_next = S_SH_RD;
            end
            S_POP:
            begin
                if (tail_reg > head_reg && emitted_reg < DW'(MAX_NODES))
                begin
                    if (mode_reg == MODE_DFS)
                    begin
                        pop_node  = wl_reg[IW'(tail_reg - DW'(1))];
                        tail_next = tail_reg - DW'(1);
                    end
                    else
                    begin
                        pop_node  = wl_reg[head_reg[IW-1:0]];
                        head_next = head_reg + DW'(1);
                    end
                    if (pop_node != '0 && DW'(pop_node) <= node_total_reg)
                    begin
                        cur_next     = pop_node;
                        emitted_next = emitted_reg + DW'(1);
                        state_next   = S_EMIT;
                    end
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_EMIT:
            begin
                if (!held_valid_reg || out_free)
                begin
                    if (held_valid_reg)
                    begin
                        rsp_valid_next  = 1'b1;
                        rsp_status_next = ST_OK;
                        rsp_num_next    = NODE_W'(held_reg);
                        rsp_cnt_next    = '0;
                        rsp_last_next   = 1'b0;
                    end
                    held_next       = cur_reg;
                    held_valid_next = 1'b1;
                    sn_next         = cur_reg;
                    k_next          = '0;
                    pend_next       = 1'b0;
                    state_next      = S_SCAN;
                end
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    rsp_valid_next  = 1'b1;
                    rsp_status_next = ST_OK;
                    rsp_num_next    = NODE_W'(held_reg);
                    rsp_cnt_next    = cnt_reg;
                    rsp_last_next   = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            S_RESP:
            begin
                if (out_free)
                begin
                    rsp_valid_next  = 1'b1;
                    rsp_status_next = st_reg;
                    rsp_num_next    = num_reg;
                    rsp_cnt_next    = '0;
                    rsp_last_next   = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            node_total_reg <= '0;
            visited_reg    <= '0;
            head_reg       <= '0;
            tail_reg       <= '0;
            held_valid_reg <= 1'b0;
            pend_reg       <= 1'b0;
            rsp_valid_reg  <= 1'b0;
            for (int i = 0; i < MAX_NODES; i++)
            begin
                deg_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg      <= state_next;
            node_total_reg <= node_total_next;
            visited_reg    <= visited_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            held_valid_reg <= held_valid_next;
            pend_reg       <= pend_next;
            rsp_valid_reg  <= rsp_valid_next;
            deg_reg        <= deg_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg       <= mode_next;
        a_reg          <= a_next;
        b_reg          <= b_next;
        cnt_reg        <= cnt_next;
        emitted_reg    <= emitted_next;
        held_reg       <= held_next;
        cur_reg        <= cur_next;
        sn_reg         <= sn_next;
        sv_reg         <= sv_next;
        k_reg          <= k_next;
        kd_reg         <= kd_next;
        found_reg      <= found_next;
        pos_reg        <= pos_next;
        phase_reg      <= phase_next;
        st_reg         <= st_next;
        num_reg        <= num_next;
        rsp_status_reg <= rsp_status_next;
        rsp_num_reg    <= rsp_num_next;
        rsp_cnt_reg    <= rsp_cnt_next;
        rsp_last_reg   <= rsp_last_next;
        if (wl_we)
        begin
            wl_reg[wl_idx] <= wl_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

`ifndef SYNTH
    a_head_le_tail: assert property (@(posedge clk) disable iff (!rst_n)
        head_reg <= tail_reg)
        else $error("Work list head passed its tail.");

    a_tail_bound: assert property (@(posedge clk) disable iff (!rst_n)
        tail_reg <= DW'(MAX_NODES))
        else $error("Work list grew beyond the node limit.");

    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        node_total_reg <= DW'(MAX_NODES))
        else $error("Node count exceeds the node limit.");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (k_reg <= sdeg))
        else $error("List scan index ran past the node degree.");
`endif

endmodule

/* sim/graph_traversal_engine_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Graph traversal engine checker
// Watches the command and result channels, keeps its own copy of the graph,
// predicts every result beat and compares each one field by field.
// ----------------------------------------------------------------------------
module graph_traversal_engine_checker
    import gte_pkg::*;
#(
    parameter int MAX_NODES = MAX_NODES_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    gte_cmd_if   cmd,
    gte_rsp_if   rsp,
    output int   fail_count,
    output int   pending
);

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [NODE_W-1:0]   visit_node;
        logic [COUNT_W-1:0]  revisit_count;
        logic                last;
    } beat_t;

    beat_t expected_beats[$];
    int    node_total;
    int    degree[MAX_NODES];
    int    adj[MAX_NODES][MAX_NODES];

    function automatic beat_t mk(logic [STATUS_W-1:0] st, int num);
        beat_t b;
        b.status        = st;
        b.visit_node    = num[NODE_W-1:0];
        b.revisit_count = '0;
        b.last          = 1'b1;
        return b;
    endfunction

    function automatic int find_pos(int n, int v);
        for (int k = 0; k < degree[n-1]; k++)
            if (adj[n-1][k] == v)
                return k;
        return -1;
    endfunction

    function automatic void drop_at(int n, int pos);
        for (int k = pos; k + 1 < degree[n-1]; k++)
            adj[n-1][k] = adj[n-1][k+1];
        degree[n-1]--;
    endfunction

    function automatic void link(int n, int v);
        adj[n-1][degree[n-1]] = v;
        degree[n-1]++;
    endfunction

    function automatic void traverse(int start, bit depth_first);
        bit    seen[MAX_NODES];
        int    work[MAX_NODES];
        int    head;
        int    tail;
        int    cnt;
        int    emitted;
        int    cur;
        int    nb;
        beat_t b;
        head = 0;
        tail = 0;
        cnt = 0;
        emitted = 0;
        foreach (seen[i]) seen[i] = 1'b0;
        work[tail++] = start;
        seen[start-1] = 1'b1;
        while (tail > head && emitted < MAX_NODES) begin
            if (depth_first)
                cur = work[--tail];
            else
                cur = work[head++];
            if (cur == 0 || cur > node_total)
                continue;
            b = mk(ST_OK, cur);
            b.last = 1'b0;
            expected_beats.push_back(b);
            emitted++;
            for (int k = 0; k < degree[cur-1]; k++) begin
                nb = adj[cur-1][k];
                if (!seen[nb-1] && tail < MAX_NODES) begin
                    work[tail++] = nb;
                    seen[nb-1] = 1'b1;
                end
                else if (cnt < COUNT_MAX) begin
                    cnt++;
                end
            end
        end
        b = expected_beats.pop_back();
        b.revisit_count = cnt[COUNT_W-1:0];
        b.last = 1'b1;
        expected_beats.push_back(b);
    endfunction

    function automatic void predict_command(logic [MODE_W-1:0] m, int a, int b);
        int pa;
        int pb;
        if (m > MODE_DFS)
            return;
        if (m == MODE_ADD_NODE) begin
            if (node_total >= MAX_NODES) begin
                expected_beats.push_back(mk(ST_FULL, 0));
            end
            else begin
                node_total++;
                degree[node_total-1] = 0;
                expected_beats.push_back(mk(ST_OK, node_total));
            end
            return;
        end
        if (node_total == 0) begin
            expected_beats.push_back(mk(ST_EMPTY, 0));
            return;
        end
        if (m == MODE_ADD_EDGE || m == MODE_DEL_EDGE) begin
            if (a == 0 || a > node_total || b == 0 || b > node_total) begin
                expected_beats.push_back(mk(ST_MISSING, 0));
                return;
            end
            pa = find_pos(a, b);
            if (m == MODE_ADD_EDGE) begin
                if (pa >= 0) begin
                    expected_beats.push_back(mk(ST_EXISTS, 0));
                    return;
                end
                if (degree[a-1] >= MAX_NODES || degree[b-1] >= MAX_NODES) begin
                    expected_beats.push_back(mk(ST_FULL, 0));
                    return;
                end
                link(a, b);
                if (a != b && find_pos(b, a) < 0)
                    link(b, a);
            end
            else begin
                if (pa < 0) begin
                    expected_beats.push_back(mk(ST_ABSENT, 0));
                    return;
                end
                drop_at(a, pa);
                if (a != b) begin
                    pb = find_pos(b, a);
                    if (pb >= 0)
                        drop_at(b, pb);
                end
            end
            expected_beats.push_back(mk(ST_OK, 0));
            return;
        end
        if (a == 0 || a > node_total) begin
            expected_beats.push_back(mk(ST_MISSING, 0));
            return;
        end
        traverse(a, m == MODE_DFS);
    endfunction

    always @(posedge clk or negedge rst_n) begin
        beat_t got;
        beat_t want;
        if (!rst_n) begin
            node_total = 0;
            fail_count <= 0;
            pending    <= 0;
            foreach (degree[i]) degree[i] = 0;
            expected_beats.delete();
        end
        else begin
            if (rsp.valid && rsp.ready) begin
                got = {rsp.status, rsp.visit_node, rsp.revisit_count, rsp.last};
                if (expected_beats.size() == 0) begin
                    if (fail_count < 10)
                        $display("ERROR: unexpected result beat %p", got);
                    fail_count <= fail_count + 1;
                end
                else begin
                    want = expected_beats.pop_front();
                    if (got !== want) begin
                        if (fail_count < 10)
                            $display("ERROR: result beat mismatch, expected %p, actual %p",
                                     want, got);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (cmd.valid && cmd.ready)
                predict_command(cmd.mode, int'(cmd.node_a), int'(cmd.node_b));
            pending <= expected_beats.size();
        end
    end

endmodule

/* sim/graph_traversal_engine_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Graph traversal engine testbench
// Builds graphs with node and edge commands, edits them and runs both
// traversals under random bursts and stalls; the checker judges every beat.
// ----------------------------------------------------------------------------
module graph_traversal_engine_tb;
    import gte_pkg::*;

    localparam int MAX_N = MAX_NODES_DEF;
    localparam int WATCHDOG_LIMIT = 200000;

    localparam logic [MODE_W-1:0] MODE_BAD_LO = 3'd5;
    localparam logic [MODE_W-1:0] MODE_BAD_HI = 3'd7;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending;
    int   idle_cycles;
    bit   long_hold;
    int   hold_left;

    gte_cmd_if cmd ();
    gte_rsp_if rsp ();

    graph_traversal_engine #(.MAX_NODES(MAX_N)) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd.sink),
        .rsp   (rsp.source)
    );

    graph_traversal_engine_checker #(.MAX_NODES(MAX_N)) checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .rsp        (rsp),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    initial
    begin
        cmd.valid  = 1'b0;
        cmd.mode   = '0;
        cmd.node_a = '0;
        cmd.node_b = '0;
        long_hold  = 1'b0;
        rst_n      = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            rsp.ready <= 1'b0;
            hold_left <= 0;
        end
        else if (long_hold)
        begin
            rsp.ready <= 1'b0;
            hold_left <= 0;
        end
        else if (hold_left > 0)
        begin
            rsp.ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if ($urandom_range(0, 9) == 0)
        begin
            rsp.ready <= 1'b0;
            hold_left <= $urandom_range(0, 6);
        end
        else
            rsp.ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (cmd.valid && cmd.ready) || (rsp.valid && rsp.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic send(logic [MODE_W-1:0] m, int a, int b);
        cmd.valid  <= 1'b1;
        cmd.mode   <= m;
        cmd.node_a <= a[NODE_W-1:0];
        cmd.node_b <= b[NODE_W-1:0];
        do
            @(posedge clk);
        while (!cmd.ready);
    endtask

    task automatic pause(int n);
        if (n > 0)
        begin
            cmd.valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic random_command(int span);
        int r;
        int hi;
        r  = $urandom_range(0, 99);
        hi = (span > MAX_N) ? 63 : span;
        if (r < 6)
            send(MODE_ADD_NODE, $urandom_range(0, 63), $urandom_range(0, 63));
        else if (r < 50)
            send(MODE_ADD_EDGE, $urandom_range(1, hi), $urandom_range(1, hi));
        else if (r < 68)
            send(MODE_DEL_EDGE, $urandom_range(1, hi), $urandom_range(1, hi));
        else if (r < 80)
            send(MODE_BFS, $urandom_range(1, hi), $urandom_range(0, 63));
        else if (r < 92)
            send(MODE_DFS, $urandom_range(1, hi), $urandom_range(0, 63));
        else if (r < 96)
            send(MODE_W'($urandom_range(int'(MODE_ADD_NODE), int'(MODE_DFS))),
                 $urandom_range(0, 63), $urandom_range(0, 63));
        else
            send(MODE_W'($urandom_range(int'(MODE_BAD_LO), int'(MODE_BAD_HI))),
                 $urandom_range(0, 63), $urandom_range(0, 63));
    endtask

    task automatic drain();
        cmd.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
    endtask

    initial
    begin
        int burst;
        int sent;
        @(posedge rst_n);
        @(posedge clk);
        send(MODE_ADD_EDGE, 1, 2);
        send(MODE_BFS, 1, 0);
        send(MODE_DFS, 0, 0);
        send(MODE_ADD_NODE, 63, 63);
        send(MODE_ADD_EDGE, 0, 1);
        send(MODE_DFS, 1, 63);
        send(MODE_ADD_NODE, 0, 0);
        send(MODE_ADD_NODE, 0, 0);
        send(MODE_ADD_EDGE, 1, 1);
        send(MODE_ADD_EDGE, 1, 1);
        send(MODE_ADD_EDGE, 1, 3);
        send(MODE_ADD_EDGE, 3, 2);
        send(MODE_ADD_EDGE, 2, 3);
        send(MODE_ADD_EDGE, 63, 1);
        send(MODE_BFS, 1, 0);
        send(MODE_DFS, 2, 0);
        send(MODE_DEL_EDGE, 1, 1);
        send(MODE_DEL_EDGE, 1, 2);
        send(MODE_DEL_EDGE, 1, 3);
        send(MODE_BFS, 4, 0);
        send(MODE_BAD_HI, 1, 2);
        send(MODE_BAD_LO, 63, 0);
        drain();

        for (int i = 0; i < 32; i++)
            send(MODE_ADD_NODE, 0, 0);
        send(MODE_ADD_NODE, 0, 0);
        for (int i = 1; i <= MAX_N; i++)
            for (int j = i; j <= MAX_N; j += 3 + (i % 3))
                send(MODE_ADD_EDGE, i, j);
        send(MODE_ADD_EDGE, 32, 33);
        send(MODE_BFS, 32, 0);
        send(MODE_DFS, 1, 0);
        drain();

        fork
            begin
                long_hold = 1'b1;
                repeat (400) @(posedge clk);
                long_hold = 1'b0;
            end
            begin
                for (int i = 0; i < 12; i++)
                    send(MODE_DEL_EDGE, $urandom_range(1, 32), $urandom_range(1, 32));
                send(MODE_BFS, 5, 0);
                send(MODE_DFS, 7, 0);
                for (int i = 0; i < 8; i++)
                    send(MODE_ADD_EDGE, $urandom_range(1, 32), $urandom_range(1, 32));
            end
        join

        sent = 0;
        while (sent < 184)
        begin
            burst = $urandom_range(1, 12);
            for (int k = 0; k < burst; k++)
            begin
                random_command(36);
                sent++;
            end
            if ($urandom_range(0, 3) != 0)
                pause($urandom_range(1, 8));
        end
        drain();

        if (fail_count == 0 && pending == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
